[rtl/start_id_length_frame_deframer_defines.svh]
// assertion helpers shared by the deframer modules
`ifndef START_ID_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define START_ID_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SIDL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sidl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sidl_pkg;

	localparam int ByteW   = 8;
	localparam int LenW    = 6;
	localparam int PosW    = 5;
	localparam int CfgIdxW = 1;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_START_MARKER = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_LENGTH_LIMIT = 1'd1;

	// register reset values
	localparam logic [ByteW-1:0] START_MARKER_RST = 8'd170;
	localparam logic [LenW-1:0]  LENGTH_LIMIT_RST = 6'd32;

	// controller to datapath commands
	typedef struct packed {
		logic clr_count;   // restart payload count
		logic load_id;     // capture message id
		logic load_len;    // capture payload length
		logic emit_empty;  // push empty-frame result
		logic wr_payload;  // store payload byte, advance count
		logic rd_issue;    // read next stored byte into the output pipe
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_start;    // input byte equals start marker
		logic len_over;    // input byte above effective limit
		logic len_zero;    // input byte is zero
		logic data_done;   // current byte completes the payload
		logic rd_done;     // current read is the final one of the frame
		logic issue_ok;    // read stage can take a new byte
		logic empty_ok;    // output path free for an empty-frame result
	} ctrl_sts_t;

endpackage

`default_nettype wire

[rtl/sidl_byte_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sidl_byte_if;
	logic                      valid;
	logic                      ready;
	logic [sidl_pkg::ByteW-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/sidl_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sidl_result_if;
	logic                       valid;
	logic                       ready;
	logic [sidl_pkg::ByteW-1:0] frame_id;
	logic [sidl_pkg::LenW-1:0]  frame_length;
	logic [sidl_pkg::ByteW-1:0] payload_byte;
	logic [sidl_pkg::PosW-1:0]  byte_position;
	logic                       empty_frame;
	logic                       last;

	modport source (output valid, output frame_id, output frame_length,
		output payload_byte, output byte_position, output empty_frame, output last,
		input ready);
	modport sink (input valid, input frame_id, input frame_length,
		input payload_byte, input byte_position, input empty_frame, input last,
		output ready);
endinterface

`default_nettype wire

[rtl/start_id_length_frame_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Start / id / length frame deframer.
// rx carries one received byte per transaction; res carries one result per
// transaction. The block hunts for the start marker, takes an id byte and a
// length byte, then stores the payload. Over-limit lengths drop the frame.
// A zero length gives one empty-frame result, registered in the cycle after the
// length byte. After the last payload byte the stored frame is read back from
// the payload ram, one result a cycle while res is ready; the first passes the
// ram read register and then the output register. Header and payload bytes are
// taken one a cycle while rx is ready; during the read-back rx is held not
// ready, so no new frame is taken until the stored one has been read out.
// A stalled res holds the output register; the read stage stops behind it,
// and rx waits only in the length phase or during read-back.
// cfg_we writes register cfg_index (0 start marker, 1 length limit).
// Reset returns to hunting with marker 170 and limit 32; the payload ram
// needs no clearing pass.
module start_id_length_frame_deframer #(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [sidl_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [sidl_pkg::ByteW-1:0]   cfg_data,
	sidl_byte_if.sink                         rx,
	sidl_result_if.source                     res
);

	sidl_pkg::ctrl_cmd_t cmd;
	sidl_pkg::ctrl_sts_t sts;

	sidl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sidl_datapath #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (rx.rx_byte),
		.cmd           (cmd),
		.sts           (sts),
		.res_ready     (res.ready),
		.res_valid     (res.valid),
		.frame_id      (res.frame_id),
		.frame_length  (res.frame_length),
		.payload_byte  (res.payload_byte),
		.byte_position (res.byte_position),
		.empty_frame   (res.empty_frame),
		.last          (res.last)
	);

endmodule

`default_nettype wire

[rtl/sidl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module sidl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read that holds when not enabled
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/sidl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "start_id_length_frame_deframer_defines.svh"

module sidl_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rx_valid,
	output logic                     rx_ready,
	input  wire sidl_pkg::ctrl_sts_t sts,
	output sidl_pkg::ctrl_cmd_t      cmd
);

	localparam logic [2:0] ST_HUNT  = 3'd0;
	localparam logic [2:0] ST_ID    = 3'd1;
	localparam logic [2:0] ST_LEN   = 3'd2;
	localparam logic [2:0] ST_DATA  = 3'd3;
	localparam logic [2:0] ST_BURST = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rx_cmd;

	// any command that consumes an input byte
	assign rx_cmd = cmd.wr_payload || cmd.load_id || cmd.load_len;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		rx_ready = 1'b0;
		unique case (state_q)
			ST_HUNT: begin
				rx_ready = 1'b1;
				if (rx_valid && sts.is_start) begin
					cmd.clr_count = 1'b1;
					state_d       = ST_ID;
				end
			end
			ST_ID: begin
				rx_ready = 1'b1;
				if (rx_valid) begin
					cmd.load_id = 1'b1;
					state_d     = ST_LEN;
				end
			end
			ST_LEN: begin
				// a zero length needs the output path right away
				rx_ready = sts.empty_ok;
				if (rx_valid && sts.empty_ok) begin
					cmd.clr_count = 1'b1;
					if (sts.len_over) begin
						state_d = ST_HUNT;
					end else if (sts.len_zero) begin
						cmd.load_len   = 1'b1;
						cmd.emit_empty = 1'b1;
						state_d        = ST_HUNT;
					end else begin
						cmd.load_len = 1'b1;
						state_d      = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				rx_ready = 1'b1;
				if (rx_valid) begin
					cmd.wr_payload = 1'b1;
					if (sts.data_done) begin
						state_d = ST_BURST;
					end
				end
			end
			ST_BURST: begin
				// read the stored payload back, one byte a cycle while the read stage can take it
				if (sts.issue_ok) begin
					cmd.rd_issue = 1'b1;
					if (sts.rd_done) begin
						state_d = ST_HUNT;
					end
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	`SIDL_ASSERT_NOW(a_burst_blocks_input, state_q == ST_BURST, !rx_ready, "input taken in burst")
	`SIDL_ASSERT_NOW(a_read_alone, cmd.rd_issue, !rx_cmd, "read mixed with input commands")
	`SIDL_ASSERT_NEXT(a_empty_to_hunt, cmd.emit_empty, state_q == ST_HUNT, "no hunt after empty")

endmodule

`default_nettype wire

[rtl/sidl_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "start_id_length_frame_deframer_defines.svh"

module sidl_datapath #(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [sidl_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [sidl_pkg::ByteW-1:0]        cfg_data,
	input  wire logic [sidl_pkg::ByteW-1:0]        rx_byte,
	input  wire sidl_pkg::ctrl_cmd_t               cmd,
	output sidl_pkg::ctrl_sts_t                    sts,
	input  wire logic                              res_ready,
	output logic                                   res_valid,
	output logic [sidl_pkg::ByteW-1:0]             frame_id,
	output logic [sidl_pkg::LenW-1:0]              frame_length,
	output logic [sidl_pkg::ByteW-1:0]             payload_byte,
	output logic [sidl_pkg::PosW-1:0]              byte_position,
	output logic                                   empty_frame,
	output logic                                   last
);

	localparam int AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [sidl_pkg::LenW:0] MaxLen = (sidl_pkg::LenW + 1)'(MAX_PAYLOAD);

	// configuration
	logic [sidl_pkg::ByteW-1:0] start_marker_q;
	logic [sidl_pkg::LenW-1:0]  length_limit_q;

	// frame state
	logic [sidl_pkg::ByteW-1:0] held_id_q;
	logic [sidl_pkg::LenW-1:0]  held_len_q;
	logic [sidl_pkg::LenW-1:0]  count_q;
	logic [sidl_pkg::LenW-1:0]  rd_ptr_q;

	// read stage
	logic                       valid_s1;
	logic [sidl_pkg::ByteW-1:0] msg_id_s1;
	logic [sidl_pkg::LenW-1:0]  len_s1;
	logic [sidl_pkg::PosW-1:0]  pos_s1;
	logic                       last_s1;
	logic [sidl_pkg::ByteW-1:0] ram_rdata;

	// output register
	logic                       out_valid_q;
	logic [sidl_pkg::ByteW-1:0] out_id_q;
	logic [sidl_pkg::LenW-1:0]  out_len_q;
	logic [sidl_pkg::ByteW-1:0] out_byte_q;
	logic [sidl_pkg::PosW-1:0]  out_pos_q;
	logic                       out_empty_q;
	logic                       out_last_q;

	logic [sidl_pkg::LenW:0]    eff_limit;
	logic [sidl_pkg::LenW:0]    count_inc;
	logic [sidl_pkg::LenW:0]    rd_inc;
	logic                       s1_move;
	logic                       count_in_range;

	// limit clipped to the store size
	assign eff_limit = ({1'b0, length_limit_q} > MaxLen) ? MaxLen : {1'b0, length_limit_q};
	assign count_inc = {1'b0, count_q} + 1'b1;
	assign rd_inc    = {1'b0, rd_ptr_q} + 1'b1;
	assign s1_move   = valid_s1 && (!out_valid_q || res_ready);
	assign count_in_range = {1'b0, count_q} < MaxLen;

	// status to the controller
	always_comb begin
		sts.is_start  = rx_byte == start_marker_q;
		sts.len_over  = rx_byte > {1'b0, eff_limit};
		sts.len_zero  = rx_byte == '0;
		sts.data_done = count_inc >= {1'b0, held_len_q};
		sts.rd_done   = rd_inc >= {1'b0, held_len_q};
		sts.issue_ok  = !valid_s1 || s1_move;
		sts.empty_ok  = !valid_s1 && (!out_valid_q || res_ready);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= sidl_pkg::START_MARKER_RST;
			length_limit_q <= sidl_pkg::LENGTH_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sidl_pkg::REG_START_MARKER: start_marker_q <= cfg_data;
				sidl_pkg::REG_LENGTH_LIMIT: length_limit_q <= cfg_data[sidl_pkg::LenW-1:0];
				default: ;
			endcase
		end
	end

	// header capture and payload counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_id_q  <= '0;
			held_len_q <= '0;
			count_q    <= '0;
			rd_ptr_q   <= '0;
		end else begin
			if (cmd.load_id) begin
				held_id_q <= rx_byte;
			end
			if (cmd.load_len) begin
				held_len_q <= rx_byte[sidl_pkg::LenW-1:0];
			end
			if (cmd.clr_count) begin
				count_q <= '0;
			end else if (cmd.wr_payload) begin
				count_q <= count_inc[sidl_pkg::LenW-1:0];
			end
			if (cmd.wr_payload) begin
				rd_ptr_q <= '0;
			end else if (cmd.rd_issue) begin
				rd_ptr_q <= rd_inc[sidl_pkg::LenW-1:0];
			end
		end
	end

	sidl_ram #(
		.WIDTH (sidl_pkg::ByteW),
		.DEPTH (MAX_PAYLOAD),
		.AW    (AddrW)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_payload),
		.waddr (count_q[AddrW-1:0]),
		.wdata (rx_byte),
		.re    (cmd.rd_issue),
		.raddr (rd_ptr_q[AddrW-1:0]),
		.rdata (ram_rdata)
	);

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.rd_issue) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage side fields travel with the ram data
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			msg_id_s1 <= held_id_q;
			len_s1    <= held_len_q;
			pos_s1    <= rd_ptr_q[sidl_pkg::PosW-1:0];
			last_s1   <= sts.rd_done;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_empty || s1_move) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			out_id_q    <= held_id_q;
			out_len_q   <= '0;
			out_byte_q  <= '0;
			out_pos_q   <= '0;
			out_empty_q <= 1'b1;
			out_last_q  <= 1'b1;
		end else if (s1_move) begin
			out_id_q    <= msg_id_s1;
			out_len_q   <= len_s1;
			out_byte_q  <= ram_rdata;
			out_pos_q   <= pos_s1;
			out_empty_q <= 1'b0;
			out_last_q  <= last_s1;
		end
	end

	assign res_valid     = out_valid_q;
	assign frame_id      = out_id_q;
	assign frame_length  = out_len_q;
	assign payload_byte  = out_byte_q;
	assign byte_position = out_pos_q;
	assign empty_frame   = out_empty_q;
	assign last          = out_last_q;

	`SIDL_ASSERT_NOW(a_issue_when_free, cmd.rd_issue, sts.issue_ok, "read issued into a full stage")
	`SIDL_ASSERT_NOW(a_empty_when_free, cmd.emit_empty, sts.empty_ok, "empty result into busy output")
	`SIDL_ASSERT_NOW(a_write_in_range, cmd.wr_payload, count_in_range, "payload write beyond store")
	`SIDL_ASSERT_NEXT(a_issue_fills_s1, cmd.rd_issue, valid_s1, "read stage not filled after issue")

endmodule

`default_nettype wire

[verif/start_id_length_frame_deframer_tb.sv]
`timescale 1ns / 1ps

module start_id_length_frame_deframer_tb;

	localparam int PAYLOAD_CAP   = 32;
	localparam int CAP_AW        = $clog2(PAYLOAD_CAP);
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 60;
	localparam int PHASE_COUNT   = 6;

	typedef logic [sidl_pkg::ByteW-1:0] byte_t;

	typedef struct packed {
		logic [sidl_pkg::ByteW-1:0] frame_id;
		logic [sidl_pkg::LenW-1:0]  frame_length;
		logic [sidl_pkg::ByteW-1:0] payload_byte;
		logic [sidl_pkg::PosW-1:0]  byte_position;
		logic                       empty_frame;
		logic                       last;
	} frame_result_t;

	typedef enum logic [1:0] {HUNT, EXPECT_ID, EXPECT_LEN, COLLECT} parse_phase_t;
	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                    kind;
		logic [sidl_pkg::CfgIdxW-1:0] idx;
		logic [sidl_pkg::ByteW-1:0]   data;
		bit                           typed;
		frame_result_t                want;
	} stim_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [sidl_pkg::CfgIdxW-1:0] cfg_index;
	logic [sidl_pkg::ByteW-1:0]   cfg_data;

	sidl_byte_if   rx_if();
	sidl_result_if res_if();

	start_id_length_frame_deframer #(.MAX_PAYLOAD(PAYLOAD_CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rx(rx_if),
		.res(res_if)
	);

	// shadow of the deframer state and its registers
	parse_phase_t                shadow_phase   = HUNT;
	logic [sidl_pkg::ByteW-1:0]  shadow_marker  = sidl_pkg::START_MARKER_RST;
	logic [sidl_pkg::LenW-1:0]   shadow_limit   = sidl_pkg::LENGTH_LIMIT_RST;
	logic [sidl_pkg::ByteW-1:0]  shadow_id      = '0;
	logic [sidl_pkg::LenW-1:0]   shadow_len     = '0;
	logic [sidl_pkg::LenW-1:0]   shadow_count   = '0;
	logic [sidl_pkg::ByteW-1:0]  shadow_payload [PAYLOAD_CAP];

	frame_result_t expected_results[$];
	int            fault_count  = 0;
	int            src_gap_pct  = 0;
	int            dst_gap_pct  = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#10000000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_fault(input string what, input frame_result_t got,
			input frame_result_t want);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%s: got id=%0d len=%0d byte=%0d pos=%0d empty=%0d last=%0d",
				what, got.frame_id, got.frame_length, got.payload_byte,
				got.byte_position, got.empty_frame, got.last);
			$display("%s: want id=%0d len=%0d byte=%0d pos=%0d empty=%0d last=%0d",
				what, want.frame_id, want.frame_length, want.payload_byte,
				want.byte_position, want.empty_frame, want.last);
		end
	endtask

	// frame parser prediction for one accepted byte
	task automatic predict_frame_byte(input logic [sidl_pkg::ByteW-1:0] b);
		int unsigned eff_limit;
		int unsigned i;
		eff_limit = (shadow_limit > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(shadow_limit);
		case (shadow_phase)
			HUNT: begin
				if (b == shadow_marker) begin
					shadow_phase = EXPECT_ID;
					shadow_count = '0;
				end
			end
			EXPECT_ID: begin
				shadow_id    = b;
				shadow_phase = EXPECT_LEN;
			end
			EXPECT_LEN: begin
				shadow_count = '0;
				if (b > eff_limit) begin
					shadow_phase = HUNT;
				end else if (b == 0) begin
					shadow_len = '0;
					expected_results.push_back({shadow_id, 6'd0, 8'd0, 5'd0, 1'b1, 1'b1});
					shadow_phase = HUNT;
				end else begin
					shadow_len   = b[sidl_pkg::LenW-1:0];
					shadow_phase = COLLECT;
				end
			end
			default: begin
				if (shadow_count < PAYLOAD_CAP)
					shadow_payload[shadow_count[CAP_AW-1:0]] = b;
				shadow_count = shadow_count + 1'b1;
				if (shadow_count >= shadow_len) begin
					for (i = 0; i < shadow_len && i < PAYLOAD_CAP; i++)
						expected_results.push_back({shadow_id, shadow_len,
							shadow_payload[i[CAP_AW-1:0]], i[sidl_pkg::PosW-1:0], 1'b0,
							(i + 1 == shadow_len)});
					shadow_phase = HUNT;
				end
			end
		endcase
	endtask

	// send one byte; called and returns at a falling edge
	task automatic push_rx_byte(input logic [sidl_pkg::ByteW-1:0] b, input bit typed,
			input frame_result_t want);
		int depth_before;
		while ($urandom_range(0, 99) < src_gap_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		depth_before = expected_results.size();
		predict_frame_byte(b);
		if (typed) begin
			while (expected_results.size() > depth_before) void'(expected_results.pop_back());
			expected_results.push_back(want);
		end
		@(negedge clk);
	endtask

	// register write once the block has drained
	task automatic write_register(input logic [sidl_pkg::CfgIdxW-1:0] idx,
			input logic [sidl_pkg::ByteW-1:0] data);
		rx_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == sidl_pkg::REG_START_MARKER)
			shadow_marker = data;
		else if (idx == sidl_pkg::REG_LENGTH_LIMIT)
			shadow_limit = data[sidl_pkg::LenW-1:0];
	endtask

	function automatic stim_row_t byte_row(input logic [sidl_pkg::ByteW-1:0] b);
		byte_row = '{kind: ROW_BYTE, idx: '0, data: b, typed: 1'b0, want: '0};
	endfunction

	function automatic stim_row_t checked_row(input logic [sidl_pkg::ByteW-1:0] b,
			input frame_result_t want);
		checked_row = '{kind: ROW_BYTE, idx: '0, data: b, typed: 1'b1, want: want};
	endfunction

	function automatic stim_row_t cfg_row(input logic [sidl_pkg::CfgIdxW-1:0] idx,
			input logic [sidl_pkg::ByteW-1:0] data);
		cfg_row = '{kind: ROW_CFG, idx: idx, data: data, typed: 1'b0, want: '0};
	endfunction

	// receiver backpressure
	always @(negedge clk) begin
		res_if.ready <= ($urandom_range(0, 99) >= dst_gap_pct);
	end

	// result checking
	always @(posedge clk) begin : result_check
		frame_result_t got;
		frame_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = {res_if.frame_id, res_if.frame_length, res_if.payload_byte,
				res_if.byte_position, res_if.empty_frame, res_if.last};
			if (expected_results.size() == 0) begin
				report_fault("unexpected result", got, '0);
			end else begin
				want = expected_results.pop_front();
				if (got.frame_id !== want.frame_id
						|| got.frame_length !== want.frame_length
						|| got.payload_byte !== want.payload_byte
						|| got.byte_position !== want.byte_position
						|| got.empty_frame !== want.empty_frame
						|| got.last !== want.last)
					report_fault("result mismatch", got, want);
			end
		end
	end

	initial begin
		stim_row_t                  directed_rows[$];
		logic [sidl_pkg::ByteW-1:0] frame_bytes[$];
		logic [sidl_pkg::ByteW-1:0] phase_marker[PHASE_COUNT];
		logic [sidl_pkg::ByteW-1:0] phase_limit[PHASE_COUNT];
		int                         ph;
		int                         sent;
		int                         k;
		int                         eff_limit;
		int                         sel;
		int                         len;
		int                         cut;
		int                         drain_cycles;
		bit                         counted;

		rx_if.valid   = 1'b0;
		rx_if.rx_byte = '0;
		res_if.ready  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		arst_n        = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part: sender idles 30, receiver 85
		src_gap_pct = 30;
		dst_gap_pct = 85;

		// empty frame with zero id under reset settings
		directed_rows.push_back(byte_row(8'd170));
		directed_rows.push_back(byte_row(8'd0));
		directed_rows.push_back(checked_row(8'd0, {8'd0, 6'd0, 8'd0, 5'd0, 1'b1, 1'b1}));
		// one-byte frame, all ones
		directed_rows.push_back(byte_row(8'd170));
		directed_rows.push_back(byte_row(8'd255));
		directed_rows.push_back(byte_row(8'd1));
		directed_rows.push_back(checked_row(8'd255, {8'd255, 6'd1, 8'd255, 5'd0, 1'b0, 1'b1}));
		// length byte far above the limit
		directed_rows.push_back(byte_row(8'd170));
		directed_rows.push_back(byte_row(8'd90));
		directed_rows.push_back(byte_row(8'd255));
		// limit above capacity clamps at capacity
		directed_rows.push_back(cfg_row(sidl_pkg::REG_LENGTH_LIMIT, 8'd63));
		directed_rows.push_back(byte_row(8'd170));
		directed_rows.push_back(byte_row(8'd34));
		directed_rows.push_back(byte_row(8'd33));
		// zero limit passes only empty frames
		directed_rows.push_back(cfg_row(sidl_pkg::REG_LENGTH_LIMIT, 8'd0));
		directed_rows.push_back(byte_row(8'd170));
		directed_rows.push_back(byte_row(8'd1));
		directed_rows.push_back(byte_row(8'd1));
		directed_rows.push_back(byte_row(8'd170));
		directed_rows.push_back(byte_row(8'd2));
		directed_rows.push_back(checked_row(8'd0, {8'd2, 6'd0, 8'd0, 5'd0, 1'b1, 1'b1}));
		// marker of zero, marker value inside the frame, limit change mid-frame
		directed_rows.push_back(cfg_row(sidl_pkg::REG_START_MARKER, 8'd0));
		directed_rows.push_back(cfg_row(sidl_pkg::REG_LENGTH_LIMIT, 8'hE3));
		directed_rows.push_back(byte_row(8'd0));
		directed_rows.push_back(byte_row(8'd0));
		directed_rows.push_back(byte_row(8'd3));
		directed_rows.push_back(byte_row(8'd0));
		directed_rows.push_back(cfg_row(sidl_pkg::REG_LENGTH_LIMIT, 8'd1));
		directed_rows.push_back(byte_row(8'd255));
		directed_rows.push_back(byte_row(8'd128));

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG)
				write_register(directed_rows[r].idx, directed_rows[r].data);
			else
				push_rx_byte(directed_rows[r].data, directed_rows[r].typed,
					directed_rows[r].want);
		end

		// settings per random phase, extremes included
		phase_marker = '{8'd170, 8'd255, 8'd0, 8'd0, 8'd0, 8'd170};
		phase_limit  = '{8'd32, 8'd5, 8'd63, 8'd0, 8'd0, 8'd32};
		phase_marker[3] = byte_t'($urandom_range(0, 255));
		phase_marker[4] = byte_t'($urandom_range(0, 255));
		phase_limit[4]  = byte_t'($urandom_range(1, 32));

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			// idle pattern: sender light / receiver heavy, then swapped, then none
			src_gap_pct = (ph < 2) ? 30 : (ph < 4) ? 85 : 0;
			dst_gap_pct = (ph < 2) ? 85 : (ph < 4) ? 30 : 0;
			write_register(sidl_pkg::REG_START_MARKER, phase_marker[ph]);
			write_register(sidl_pkg::REG_LENGTH_LIMIT, phase_limit[ph]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				frame_bytes.delete();
				eff_limit = (shadow_limit > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(shadow_limit);
				counted = ($urandom_range(0, 99) >= 8);
				if (!counted) begin
					// line noise
					repeat ($urandom_range(1, 6))
						frame_bytes.push_back(byte_t'($urandom_range(0, 255)));
				end else begin
					// well-formed header with random content
					frame_bytes.push_back(shadow_marker);
					frame_bytes.push_back(($urandom_range(0, 9) == 0) ? shadow_marker
						: byte_t'($urandom_range(0, 255)));
					sel = $urandom_range(0, 99);
					if (sel < 10 || (eff_limit == 0 && sel < 92))
						len = 0;
					else if (sel < 65)
						len = $urandom_range(1, (eff_limit < 4) ? eff_limit : 4);
					else if (sel < 85)
						len = $urandom_range(1, eff_limit);
					else if (sel < 92)
						len = eff_limit;
					else
						len = $urandom_range(eff_limit + 1, 255);
					frame_bytes.push_back(byte_t'(len));
					if (len <= eff_limit) begin
						// truncate now and then so the next frame lands in the payload
						cut = len;
						if (len > 1 && $urandom_range(0, 99) < 5)
							cut = $urandom_range(1, len - 1);
						for (k = 0; k < cut; k++)
							frame_bytes.push_back(($urandom_range(0, 9) == 0) ? shadow_marker
								: byte_t'($urandom_range(0, 255)));
					end
				end
				foreach (frame_bytes[b]) begin
					push_rx_byte(frame_bytes[b], 1'b0, '0);
					sent++;
				end
			end
		end

		// wait for the last results, then a short settle
		rx_if.valid <= 1'b0;
		for (drain_cycles = 0; expected_results.size() != 0 && drain_cycles < 50000;
				drain_cycles++)
			@(negedge clk);
		repeat (4 * SETTLE_CYCLES) @(negedge clk);
		while (expected_results.size() != 0)
			report_fault("missing result", '0, expected_results.pop_front());

		if (fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
